[rtl/uartrx_pkg.sv]
// Shared types and constants of the UART receiver core.
package uartrx_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DATA_BITS_DEFAULT   = 8;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Widths of the control and status register port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register values after reset.
   localparam logic [15:0] CLOCKS_PER_BIT_RESET = 16'd434;
   localparam logic [1:0]  PARITY_MODE_RESET    = 2'd0;
   localparam logic [1:0]  STOP_BITS_RESET      = 2'd1;

   // Register indexes on the control port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CLOCKS_PER_BIT = 2'd0,
      CSR_PARITY_MODE    = 2'd1,
      CSR_STOP_BITS      = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // Parity mode codes; the spare code behaves as no parity.
   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_EVEN = 2'd1;
   localparam logic [1:0] PARITY_ODD  = 2'd2;

   // Stop bit counts.
   localparam logic [3:0] STOP_ONE = 4'd1;
   localparam logic [3:0] STOP_TWO = 4'd2;

   // Frame phase of the receiver.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_DATA   = 3'd2,
      PH_PARITY = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   // One received character with its check flags.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       parity_error;
      logic       framing_error;
   } rsp_type;

endpackage

[rtl/uart_receiver_core.sv]
// UART receiver core: line sampling, frame checking and a buffered result port.
//
//   Channel   Ports                               Moves
//   req       req_valid/req_ready, req_rx_line    one line sample per request
//   rsp       rsp_valid/rsp_ready, rsp_*          one received character with flags
//   csr       csr_valid/csr_ready, csr_index/data register write, always ready
//
// One request is taken every cycle while the skid stage is free; the frame machine
// updates on the edge that accepts it, and a finished character is registered.
// The result register is backed by a one-entry skid stage, so a stalled rsp side only
// blocks req once both are full. Reset is synchronous and clears all control state.
module uart_receiver_core #(
   parameter int DATA_BITS   = uartrx_pkg::DATA_BITS_DEFAULT,
   parameter int COUNT_WIDTH = uartrx_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_rx_line,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [7:0]                             rsp_data_byte,
   output logic                                   rsp_parity_error,
   output logic                                   rsp_framing_error,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [uartrx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [uartrx_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import uartrx_pkg::*;

   // Compare width covers both the divisor and the tick counter.
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [3:0] DATA_BITS_IDX = 4'(DATA_BITS);

   // Configuration registers.
   logic [15:0] clocks_per_bit_ff;
   logic [1:0]  parity_mode_ff;
   logic [1:0]  stop_bits_ff;

   // Frame state.
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [3:0]             bit_index_ff, bit_index_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic                   parity_accum_ff, parity_accum_in;
   logic                   stop_fail_ff, stop_fail_in;
   logic                   parity_fail_ff, parity_fail_in;

   // Result register and skid stage.
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   // Working signals.
   logic                   accept;
   logic [COUNT_WIDTH-1:0] tick_sat;
   logic [15:0]            target;
   logic [CMP_WIDTH-1:0]   target_clip;
   logic                   reached;
   logic [3:0]             nstop;
   logic                   parity_on;
   logic [15:0]            shift_wide;
   rsp_type                res_new;
   logic                   res_new_valid;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // Register writes; an unused index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         clocks_per_bit_ff <= CLOCKS_PER_BIT_RESET;
         parity_mode_ff    <= PARITY_MODE_RESET;
         stop_bits_ff      <= STOP_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLOCKS_PER_BIT: clocks_per_bit_ff <= csr_data[15:0];
            CSR_PARITY_MODE:    parity_mode_ff    <= csr_data[1:0];
            CSR_STOP_BITS:      stop_bits_ff      <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Saturating tick counter and the sample point for the current phase.
   always_comb begin
      tick_sat    = (tick_ff == COUNT_MAX) ? tick_ff : tick_ff + 1'b1;
      target      = (phase_ff == PH_START) ? (clocks_per_bit_ff >> 1) : clocks_per_bit_ff;
      target_clip = (CMP_WIDTH'(target) > CMP_WIDTH'(COUNT_MAX)) ?
                    CMP_WIDTH'(COUNT_MAX) : CMP_WIDTH'(target);
      reached     = CMP_WIDTH'(tick_sat) >= target_clip;
      nstop       = (stop_bits_ff >= 2'd2) ? STOP_TWO : STOP_ONE;
      parity_on   = (parity_mode_ff == PARITY_EVEN) || (parity_mode_ff == PARITY_ODD);
      shift_wide  = 16'(shift_ff);
   end

   // Next state of the frame machine for one accepted line sample.
   always_comb begin
      phase_in        = phase_ff;
      tick_in         = tick_ff;
      bit_index_in    = bit_index_ff;
      shift_in        = shift_ff;
      parity_accum_in = parity_accum_ff;
      stop_fail_in    = stop_fail_ff;
      parity_fail_in  = parity_fail_ff;
      res_new_valid   = 1'b0;
      res_new.data_byte     = shift_wide[7:0];
      res_new.parity_error  = parity_fail_ff;
      res_new.framing_error = stop_fail_ff || !req_rx_line;

      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!req_rx_line) begin
                  phase_in = PH_START;
                  tick_in  = '0;
               end
            end
            PH_START: begin
               tick_in = tick_sat;
               if (reached) begin
                  tick_in = '0;
                  if (!req_rx_line) begin
                     phase_in        = PH_DATA;
                     bit_index_in    = '0;
                     shift_in        = '0;
                     parity_accum_in = 1'b0;
                     stop_fail_in    = 1'b0;
                     parity_fail_in  = 1'b0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_DATA: begin
               tick_in = tick_sat;
               if (reached) begin
                  tick_in = '0;
                  for (int i = 0; i < DATA_BITS; i++) begin
                     if (bit_index_ff == 4'(i)) begin
                        shift_in[i] = req_rx_line;
                     end
                  end
                  parity_accum_in = parity_accum_ff ^ req_rx_line;
                  bit_index_in    = bit_index_ff + 4'd1;
                  if (bit_index_in >= DATA_BITS_IDX) begin
                     bit_index_in = '0;
                     phase_in     = parity_on ? PH_PARITY : PH_STOP;
                  end
               end
            end
            PH_PARITY: begin
               tick_in = tick_sat;
               if (reached) begin
                  tick_in = '0;
                  priority if (parity_mode_ff == PARITY_EVEN) begin
                     parity_fail_in = parity_accum_ff ^ req_rx_line;
                  end else if (parity_mode_ff == PARITY_ODD) begin
                     parity_fail_in = !(parity_accum_ff ^ req_rx_line);
                  end else begin
                     parity_fail_in = 1'b0;
                  end
                  bit_index_in = '0;
                  phase_in     = PH_STOP;
               end
            end
            PH_STOP: begin
               tick_in = tick_sat;
               if (reached) begin
                  tick_in      = '0;
                  stop_fail_in = stop_fail_ff || !req_rx_line;
                  bit_index_in = bit_index_ff + 4'd1;
                  if (bit_index_in >= nstop) begin
                     bit_index_in  = '0;
                     phase_in      = PH_IDLE;
                     res_new_valid = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase
      end
   end

   // Result register with a skid stage behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = res_new;
            skid_valid_in = res_new_valid;
         end else begin
            out_in       = res_new;
            out_valid_in = res_new_valid;
         end
      end else if (res_new_valid) begin
         skid_in       = res_new;
         skid_valid_in = 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_ff         <= '0;
         bit_index_ff    <= '0;
         shift_ff        <= '0;
         parity_accum_ff <= 1'b0;
         stop_fail_ff    <= 1'b0;
         parity_fail_ff  <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         tick_ff         <= tick_in;
         bit_index_ff    <= bit_index_in;
         shift_ff        <= shift_in;
         parity_accum_ff <= parity_accum_in;
         stop_fail_ff    <= stop_fail_in;
         parity_fail_ff  <= parity_fail_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Result port.
   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_parity_error  = out_ff.parity_error;
   assign rsp_framing_error = out_ff.framing_error;

`ifndef SYNTH
   // The skid stage only fills behind an occupied result register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while result register empty");

   // A character is only finished in the stop phase.
   a_result_in_stop: assert property (@(posedge clock) disable iff (reset)
      res_new_valid |-> (phase_ff == PH_STOP))
      else $error("result produced outside the stop phase");

   // A finished frame returns the receiver to idle.
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      res_new_valid |=> (phase_ff == PH_IDLE))
      else $error("receiver not idle after a finished frame");

   // The data bit position stays inside the character.
   a_data_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bit_index_ff < DATA_BITS_IDX))
      else $error("data bit index out of range");

   // At most two stop bits are ever counted.
   a_stop_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP) |-> (bit_index_ff < STOP_TWO))
      else $error("stop bit index out of range");
`endif

endmodule

[dv/uart_char_check.sv]
// Predicts the characters of the UART receiver from its line samples and checks each result.
`timescale 1ns / 100ps
module uart_char_check #(
   parameter int DATA_BITS   = uartrx_pkg::DATA_BITS_DEFAULT,
   parameter int COUNT_WIDTH = uartrx_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_rx_line,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [7:0]                             rsp_data_byte,
   input  logic                                   rsp_parity_error,
   input  logic                                   rsp_framing_error,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [uartrx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [uartrx_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                     fail_count,
   output int                                     pending,
   output bit                                     line_busy
);
   import uartrx_pkg::*;

   // Largest value of the bit-period counter; the counter saturates here.
   localparam int unsigned COUNT_CAP = (1 << COUNT_WIDTH) - 1;

   // Local copies of the registers.
   logic [15:0] baud_div;
   logic [1:0]  parity_sel;
   logic [1:0]  stop_sel;

   // Frame state of the predicted receiver.
   phase_type   stage;
   int unsigned bit_timer;
   logic [3:0]  bit_pos;
   logic [15:0] shift_reg;
   logic        parity_acc;
   logic        parity_bad;
   logic        stop_bad;

   // Characters predicted but not yet seen on the result channel.
   rsp_type     expected_chars[$];
   int          mismatches = 0;

   // Advances the saturating bit timer and tells whether it has reached its target.
   function automatic bit timer_done(input int unsigned target);
      if (target > COUNT_CAP) target = COUNT_CAP;
      if (bit_timer < COUNT_CAP) bit_timer++;
      return bit_timer >= target;
   endfunction

   // Reports one wrong field of a received character.
   function automatic void report_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endfunction

   // Runs one line sample through the frame state machine.
   function automatic void take_sample(input logic lvl);
      int unsigned full_period;
      int unsigned half_period;
      int unsigned stop_count;
      logic        parity_on;
      rsp_type     ch;
      full_period = 32'(baud_div);
      half_period = 32'(baud_div >> 1);
      stop_count  = (stop_sel >= 2'(STOP_TWO)) ? 2 : 1;
      parity_on   = (parity_sel == PARITY_EVEN) || (parity_sel == PARITY_ODD);
      case (stage)
         PH_IDLE: begin
            // A low line is taken as the leading edge of a start bit.
            if (!lvl) begin
               stage     = PH_START;
               bit_timer = 0;
            end
         end
         PH_START: begin
            // The start bit is checked again half a period in; high means a false start.
            if (timer_done(half_period)) begin
               bit_timer = 0;
               if (!lvl) begin
                  stage      = PH_DATA;
                  bit_pos    = '0;
                  shift_reg  = '0;
                  parity_acc = 1'b0;
                  stop_bad   = 1'b0;
                  parity_bad = 1'b0;
               end else begin
                  stage = PH_IDLE;
               end
            end
         end
         PH_DATA: begin
            // Data bits arrive least significant first, one per bit period.
            if (timer_done(full_period)) begin
               bit_timer = 0;
               if (lvl) shift_reg[bit_pos] = 1'b1;
               parity_acc = parity_acc ^ lvl;
               bit_pos    = bit_pos + 4'd1;
               if (int'(bit_pos) >= DATA_BITS) begin
                  bit_pos = '0;
                  stage   = parity_on ? PH_PARITY : PH_STOP;
               end
            end
         end
         PH_PARITY: begin
            if (timer_done(full_period)) begin
               bit_timer = 0;
               case (parity_sel)
                  PARITY_EVEN: parity_bad = parity_acc ^ lvl;
                  PARITY_ODD:  parity_bad = ~(parity_acc ^ lvl);
                  default:     parity_bad = 1'b0;
               endcase
               bit_pos = '0;
               stage   = PH_STOP;
            end
         end
         PH_STOP: begin
            // Any low stop bit flags the character, which is still delivered.
            if (timer_done(full_period)) begin
               bit_timer = 0;
               if (!lvl) stop_bad = 1'b1;
               bit_pos = bit_pos + 4'd1;
               if (32'(bit_pos) >= stop_count) begin
                  ch.data_byte     = shift_reg[7:0];
                  ch.parity_error  = parity_bad;
                  ch.framing_error = stop_bad;
                  expected_chars.push_back(ch);
                  bit_pos = '0;
                  stage   = PH_IDLE;
               end
            end
         end
         default: begin
            stage     = PH_IDLE;
            bit_timer = 0;
         end
      endcase
   endfunction

   // Compares an accepted result with the oldest predicted character.
   function automatic void check_char();
      rsp_type want;
      if (expected_chars.size() == 0) begin
         report_field("unexpected character (none expected)", 8'h00, rsp_data_byte);
         return;
      end
      want = expected_chars.pop_front();
      if (rsp_data_byte !== want.data_byte)
         report_field("data_byte", want.data_byte, rsp_data_byte);
      if (rsp_parity_error !== want.parity_error)
         report_field("parity_error", {7'd0, want.parity_error}, {7'd0, rsp_parity_error});
      if (rsp_framing_error !== want.framing_error)
         report_field("framing_error", {7'd0, want.framing_error},
                      {7'd0, rsp_framing_error});
   endfunction

   // Results are checked before the sample of the same edge, and register writes act last.
   always @(posedge clock) begin
      if (reset) begin
         baud_div   = CLOCKS_PER_BIT_RESET;
         parity_sel = PARITY_MODE_RESET;
         stop_sel   = STOP_BITS_RESET;
         stage      = PH_IDLE;
         bit_timer  = 0;
         bit_pos    = '0;
         shift_reg  = '0;
         parity_acc = 1'b0;
         parity_bad = 1'b0;
         stop_bad   = 1'b0;
         expected_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_char();
         if (req_valid && req_ready) take_sample(req_rx_line);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOCKS_PER_BIT: baud_div   = csr_data;
               CSR_PARITY_MODE:    parity_sel = csr_data[1:0];
               CSR_STOP_BITS:      stop_sel   = csr_data[1:0];
               default:            ;
            endcase
         end
      end
      fail_count <= mismatches;
      pending    <= expected_chars.size();
      line_busy  <= (stage != PH_IDLE);
   end

endmodule

[dv/testbench.sv]
// Top of the UART receiver testbench: clock, reset, line stimulus and the final verdict.
`timescale 1ns / 100ps
module testbench;
   import uartrx_pkg::*;

   localparam int CYCLE_LIMIT  = 100_000;
   localparam int HOLD_CYCLES  = 80;
   localparam int LATENCY_WAIT = 4;

   // Register values for the parity and stop count fields, some outside the documented range.
   localparam logic [1:0] PARITY_SPARE = 2'd3;
   localparam logic [1:0] STOPS_ZERO   = 2'd0;
   localparam logic [1:0] STOPS_ONE    = 2'd1;
   localparam logic [1:0] STOPS_TWO    = 2'd2;
   localparam logic [1:0] STOPS_THREE  = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_rx_line;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [7:0]                 rsp_data_byte;
   logic                       rsp_parity_error;
   logic                       rsp_framing_error;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;
   int                         fail_count;
   int                         pending;
   bit                         line_busy;

   // Register settings as last written, used to lay out frames.
   int unsigned cur_div    = 32'(CLOCKS_PER_BIT_RESET);
   logic [1:0]  cur_parity = PARITY_MODE_RESET;
   logic [1:0]  cur_stops  = STOP_BITS_RESET;

   // calm switches off random idling; squeeze asks for the long hold-off on the result side.
   bit calm    = 1'b0;
   bit squeeze = 1'b0;

   uart_receiver_core uut (.*);

   uart_char_check char_check (.*);

   // Clock with an 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the length of the run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench: FAIL");
      $finish;
   end

   // Result side: random stalls, and one long hold-off so that the block backs up.
   initial begin
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one line sample, sometimes after an idle burst, and waits until it is taken.
   task automatic put_sample(input logic lvl);
      if (!calm && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_line <= lvl;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_level(input logic lvl, input int unsigned ticks);
      repeat (ticks) put_sample(lvl);
   endtask

   // Keeps the line high until no frame is in progress and every character has arrived.
   // The first high sample makes the busy flag seen in the loop cover all earlier samples.
   task automatic settle();
      put_sample(1'b1);
      while (line_busy || pending != 0) put_sample(1'b1);
      req_valid <= 1'b0;
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic csr_push(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all registers back to back; junk goes into the unused bits of the narrow ones.
   task automatic program_regs(input logic [15:0] div, input logic [1:0] par,
                               input logic [1:0] stops, input bit touch_spare);
      logic [13:0] filler;
      filler = 14'($urandom);
      csr_push(CSR_CLOCKS_PER_BIT, div);
      csr_push(CSR_PARITY_MODE, {filler, par});
      filler = 14'($urandom);
      csr_push(CSR_STOP_BITS, {filler, stops});
      if (touch_spare) csr_push(CSR_UNUSED, 16'($urandom));
      csr_valid  <= 1'b0;
      cur_div    = 32'(div);
      cur_parity = par;
      cur_stops  = stops;
   endtask

   // Sends one character in the current format; each bit is held for one bit period.
   task automatic send_frame(input logic [7:0] value, input bit bad_parity,
                             input logic [1:0] stop_lvls);
      int unsigned width;
      int unsigned start_width;
      logic        par_bit;
      // Below a divisor of two every tick is a sample, so the start bit needs two ticks.
      width       = (cur_div < 2) ? 1 : cur_div;
      start_width = (cur_div < 2) ? 2 : cur_div;
      hold_level(1'b0, start_width);
      for (int i = 0; i < 8; i++) hold_level(value[i], width);
      if (cur_parity == PARITY_EVEN || cur_parity == PARITY_ODD) begin
         par_bit = (cur_parity == PARITY_EVEN) ? ^value : ~^value;
         hold_level(par_bit ^ bad_parity, width);
      end
      hold_level(stop_lvls[0], width);
      if (cur_stops >= STOPS_TWO) hold_level(stop_lvls[1], width);
   endtask

   // A short low pulse that the start check should reject.
   task automatic false_start();
      hold_level(1'b0, $urandom_range(1, (cur_div > 3) ? cur_div / 2 - 1 : 1));
      hold_level(1'b1, cur_div / 2 + 2);
   endtask

   // A random character, now and then with a bad parity or stop bit, and a short gap.
   task automatic random_frame();
      logic [1:0] stop_lvls;
      stop_lvls[0] = ($urandom_range(0, 7) != 0);
      stop_lvls[1] = ($urandom_range(0, 7) != 0);
      send_frame(8'($urandom), $urandom_range(0, 7) == 0, stop_lvls);
      hold_level(1'b1, $urandom_range(0, 3));
   endtask

   // Start bit and a few data bits, then the line goes high early.
   task automatic broken_frame();
      hold_level(1'b0, (cur_div < 2) ? 2 : cur_div);
      repeat ($urandom_range(1, 6))
         hold_level(1'($urandom_range(0, 1)), (cur_div < 2) ? 1 : cur_div);
      hold_level(1'b1, $urandom_range(1, 4));
   endtask

   // Main sequence.
   initial begin
      int          pick;
      logic [15:0] div;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_line <= 1'b1;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_CLOCKS_PER_BIT;
      csr_data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // One character with the parity and stop settings that reset leaves, at a short period.
      csr_push(CSR_CLOCKS_PER_BIT, 16'd4);
      csr_valid <= 1'b0;
      cur_div   = 4;
      send_frame(8'hA5, 1'b0, 2'b11);
      settle();

      // Data extremes, a false start, and a stop error with the line still low afterwards.
      program_regs(16'd4, PARITY_NONE, STOPS_ONE, 1'b1);
      send_frame(8'h00, 1'b0, 2'b11);
      send_frame(8'hFF, 1'b0, 2'b11);
      hold_level(1'b1, 2);
      false_start();
      send_frame(8'h3C, 1'b0, 2'b00);
      send_frame(8'hC3, 1'b0, 2'b11);
      settle();

      // Even parity, good and bad.
      program_regs(16'd4, PARITY_EVEN, STOPS_ONE, 1'b0);
      send_frame(8'h01, 1'b0, 2'b11);
      send_frame(8'h55, 1'b1, 2'b11);
      settle();

      // Odd parity with two stop bits, including a low second stop bit.
      program_regs(16'd4, PARITY_ODD, STOPS_TWO, 1'b0);
      send_frame(8'h7F, 1'b0, 2'b11);
      send_frame(8'hE1, 1'b0, 2'b01);
      settle();

      // The spare parity code and a stop count of zero.
      program_regs(16'd4, PARITY_SPARE, STOPS_ZERO, 1'b0);
      send_frame(8'h69, 1'b0, 2'b10);
      settle();

      // A stop count of three.
      program_regs(16'd4, PARITY_EVEN, STOPS_THREE, 1'b0);
      send_frame(8'h81, 1'b0, 2'b11);
      settle();

      // Divisors from zero to three; below two, every tick is a sample.
      for (int d = 0; d < 4; d++) begin
         program_regs(16'(d), PARITY_ODD, STOPS_ONE, 1'b0);
         send_frame(8'($urandom), 1'b0, 2'b11);
         settle();
      end

      // Random formats; most requests form well-shaped characters, the rest is line noise.
      repeat (2) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) div = 16'($urandom_range(2, 5));
         else           div = 16'($urandom_range(0, 1));
         program_regs(div, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
         calm = ($urandom_range(0, 3) == 0);
         repeat (4) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)      random_frame();
            else if (pick < 85) false_start();
            else if (pick < 93) repeat ($urandom_range(1, 24))
               put_sample(1'($urandom_range(0, 1)));
            else                broken_frame();
         end
         settle();
      end

      // Last part without idling: a long hold-off on the result side while characters
      // keep arriving back to back.
      calm = 1'b1;
      program_regs(16'd1, PARITY_EVEN, STOPS_TWO, 1'b0);
      squeeze = 1'b1;
      repeat (4) send_frame(8'($urandom), 1'b0, 2'b11);
      settle();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
